/* hw/rtl/dl_pkg.sv */
`default_nettype none

package dl_pkg;

  localparam int MAX_LEN = 64;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int CP_W    = 21;
  localparam int COST_W  = 8;
  localparam int DIST_W  = 16;
  localparam int SUM_W   = DIST_W + 2;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [1:0] ACT_SRC = 2'd0;
  localparam logic [1:0] ACT_TGT = 2'd1;
  localparam logic [1:0] ACT_CMP = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_COST = 2'd1;
  localparam logic [1:0] STAT_LONG = 2'd2;

  localparam logic [1:0] CFG_DEL = 2'd0;
  localparam logic [1:0] CFG_INS = 2'd1;
  localparam logic [1:0] CFG_REP = 2'd2;
  localparam logic [1:0] CFG_SWP = 2'd3;

  typedef struct packed {
    logic [1:0]      action;
    logic [CP_W-1:0] code_point;
  } dl_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [1:0]        status;
  } dl_out_t;

  typedef struct packed {
    logic [COST_W-1:0] del;
    logic [COST_W-1:0] ins;
    logic [COST_W-1:0] rep;
    logic [COST_W-1:0] swp;
  } dl_costs_t;

  typedef struct packed {
    logic             src_we;
    logic             tgt_we;
    logic [IDX_W-1:0] addr;
    logic [CP_W-1:0]  cp;
  } dl_wr_t;

  // z + x*y + w, and its minimum against best
  typedef struct packed {
    logic [SUM_W-1:0]  z;
    logic [CNT_W-1:0]  x;
    logic [COST_W-1:0] y;
    logic [COST_W-1:0] w;
    logic [SUM_W-1:0]  best;
  } dl_alu_op_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] min;
  } dl_alu_res_t;

  function automatic logic [DIST_W-1:0] sat16(input logic [SUM_W-1:0] v);
    sat16 = (v > SUM_W'(DIST_MAX)) ? DIST_MAX : v[DIST_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/weighted_damerau_levenshtein_top.sv */
`default_nettype none
// Channel   Direction  Payload                      Handshake
// in_       in         dl_in_t {action, code_point} in_valid / in_ready
// out_      out        dl_out_t {distance, status}  out_valid / out_ready
// cfg_      in         cfg_index, cfg_data          cfg_valid / cfg_ready
//
// A compute with both strings non-empty walks the table one cell at a time
// through the shared add/multiply/min unit, with extra swap steps for a cell
// where a swap candidate exists. Other computes answer without the walk.
// Reset is synchronous, active low, and sets all costs to 1. The input
// stalls while a compute runs or a result waits.

module weighted_damerau_levenshtein_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dl_pkg::dl_in_t                in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dl_pkg::dl_out_t               out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [dl_pkg::COST_W-1:0]     cfg_data
);
  import dl_pkg::*;

  dl_costs_t         cost_r;
  logic [CNT_W-1:0]  src_cnt_r, tgt_cnt_r;
  logic              ovf_r, busy_r, out_valid_r;
  dl_out_t           out_data_r;

  logic              in_acc, start, unsup, done;
  logic [DIST_W-1:0] eng_dist;
  logic [CNT_W+COST_W-1:0] ins_prod, del_prod;
  dl_wr_t            wr;

  assign in_ready  = !busy_r && !out_valid_r;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign unsup     = ({1'b0, cost_r.swp, 1'b0} < ({2'b0, cost_r.ins} + {2'b0, cost_r.del}));
  assign ins_prod  = (CNT_W+COST_W)'(tgt_cnt_r) * (CNT_W+COST_W)'(cost_r.ins);
  assign del_prod  = (CNT_W+COST_W)'(src_cnt_r) * (CNT_W+COST_W)'(cost_r.del);

  assign start = in_acc && (in_data.action == ACT_CMP) && !unsup && !ovf_r
                 && (src_cnt_r != '0) && (tgt_cnt_r != '0);

  always_comb begin
    wr        = '0;
    wr.cp     = in_data.code_point;
    if (in_data.action == ACT_TGT) begin
      wr.addr = IDX_W'(tgt_cnt_r);
    end else begin
      wr.addr = IDX_W'(src_cnt_r);
    end
    wr.src_we = in_acc && (in_data.action == ACT_SRC) && (src_cnt_r < CNT_W'(MAX_LEN));
    wr.tgt_we = in_acc && (in_data.action == ACT_TGT) && (tgt_cnt_r < CNT_W'(MAX_LEN));
  end

  dl_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_i   (wr),
    .start_i(start),
    .ns_i   (src_cnt_r),
    .nt_i   (tgt_cnt_r),
    .cost_i (cost_r),
    .done_o (done),
    .dist_o (eng_dist)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r      <= '{del: COST_W'(1), ins: COST_W'(1), rep: COST_W'(1), swp: COST_W'(1)};
      src_cnt_r   <= '0;
      tgt_cnt_r   <= '0;
      ovf_r       <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEL: cost_r.del <= cfg_data;
          CFG_INS: cost_r.ins <= cfg_data;
          CFG_REP: cost_r.rep <= cfg_data;
          CFG_SWP: cost_r.swp <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (done) begin
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
        out_data_r  <= '{distance: eng_dist, status: STAT_OK};
      end
      if (in_acc) begin
        case (in_data.action)
          ACT_SRC: begin
            if (wr.src_we) begin
              src_cnt_r <= src_cnt_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
          end
          ACT_TGT: begin
            if (wr.tgt_we) begin
              tgt_cnt_r <= tgt_cnt_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
          end
          ACT_CMP: begin
            src_cnt_r <= '0;
            tgt_cnt_r <= '0;
            ovf_r     <= 1'b0;
            if (start) begin
              busy_r <= 1'b1;
            end else begin
              out_valid_r <= 1'b1;
              if (unsup) begin
                out_data_r <= '{distance: '0, status: STAT_COST};
              end else if (ovf_r) begin
                out_data_r <= '{distance: '0, status: STAT_LONG};
              end else if (src_cnt_r == '0) begin
                out_data_r <= '{distance: sat16(SUM_W'(ins_prod)), status: STAT_OK};
              end else begin
                out_data_r <= '{distance: sat16(SUM_W'(del_prod)), status: STAT_OK};
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* hw/rtl/dl_alu.sv */
`default_nettype none

module dl_alu (
  input  dl_pkg::dl_alu_op_t  op_i,
  output dl_pkg::dl_alu_res_t res_o
);
  import dl_pkg::*;

  logic [CNT_W+COST_W-1:0] prod;
  logic [SUM_W-1:0]        sum;

  assign prod = CNT_W'(op_i.x) * (CNT_W+COST_W)'(op_i.y);
  assign sum  = op_i.z + SUM_W'(prod) + SUM_W'(op_i.w);

  assign res_o.sum = sum;
  assign res_o.min = (sum < op_i.best) ? sum : op_i.best;

endmodule

`default_nettype wire

/* hw/rtl/dl_engine.sv */
`default_nettype none

module dl_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dl_pkg::dl_wr_t                 wr_i,
  input  logic                           start_i,
  input  logic [dl_pkg::CNT_W-1:0]       ns_i,
  input  logic [dl_pkg::CNT_W-1:0]       nt_i,
  input  dl_pkg::dl_costs_t              cost_i,
  output logic                           done_o,
  output logic [dl_pkg::DIST_W-1:0]      dist_o
);
  import dl_pkg::*;

  typedef enum logic [2:0] {
    E_IDLE, E_FETCH, E_CALC, E_PRE, E_SW1, E_SW2, E_WRITE
  } state_t;

  typedef enum logic [1:0] {K_00, K_ROW0, K_COL0, K_IN} kind_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] k;
  } lk_t;

  logic [CP_W-1:0]   src_mem [MAX_LEN];
  logic [CP_W-1:0]   tgt_mem [MAX_LEN];
  logic [DIST_W-1:0] cost_mem [MAX_LEN*MAX_LEN];
  lk_t               lk_mem [MAX_LEN];

  state_t            state_r;
  logic [IDX_W-1:0]  i_r, j_r, ilast_r, jlast_r, js_r;
  logic [1:0]        step_r;
  logic              rm_valid_r, done_r;
  logic [CP_W-1:0]   src_q, tgt_q;
  logic [DIST_W-1:0] rd_q, up_r, left_r, diag_r, dist_r;
  lk_t               lk_q;
  logic [SUM_W-1:0]  best_r, tmp_r;

  kind_t             kind;
  logic              eq, do_swap, pre_zero;
  logic [IDX_W-1:0]  prow, pcol, im1, ikd, jjd;
  logic [ADDR_W-1:0] rd_addr;
  logic [SUM_W-1:0]  rep_z;
  logic [DIST_W-1:0] tbl_val;
  dl_alu_op_t        op;
  dl_alu_res_t       res;

  dl_alu u_alu (.op_i(op), .res_o(res));

  always_comb begin
    if (i_r == '0 && j_r == '0) begin
      kind = K_00;
    end else if (i_r == '0) begin
      kind = K_ROW0;
    end else if (j_r == '0) begin
      kind = K_COL0;
    end else begin
      kind = K_IN;
    end
  end

  assign eq       = (src_q == tgt_q);
  assign rep_z    = eq ? '0 : SUM_W'(cost_i.rep);
  assign do_swap  = (kind == K_IN) && lk_q.valid && rm_valid_r;
  assign pre_zero = (lk_q.k == '0) && (js_r == '0);
  assign prow     = (lk_q.k != '0) ? lk_q.k - 1'b1 : '0;
  assign pcol     = (js_r != '0) ? js_r - 1'b1 : '0;
  assign im1      = i_r - 1'b1;
  assign ikd      = i_r - lk_q.k - 1'b1;
  assign jjd      = j_r - js_r - 1'b1;
  assign rd_addr  = (state_r == E_PRE) ? {prow, pcol} : {im1, j_r};
  assign tbl_val  = sat16(best_r);

  always_comb begin
    op      = '0;
    op.best = best_r;
    case (state_r)
      E_CALC: begin
        case (kind)
          K_00: begin
            if (step_r == 2'd0) begin
              op.x = CNT_W'(1);
              op.y = cost_i.del;
              op.w = cost_i.ins;
            end else begin
              op.z = rep_z;
            end
          end
          K_ROW0: begin
            case (step_r)
              2'd0: begin
                op.x = CNT_W'(j_r) + 1'b1;
                op.y = cost_i.ins;
                op.w = cost_i.del;
              end
              2'd1: begin
                op.z = SUM_W'(left_r);
                op.x = CNT_W'(1);
                op.y = cost_i.ins;
              end
              default: begin
                op.z = rep_z;
                op.x = CNT_W'(j_r);
                op.y = cost_i.ins;
              end
            endcase
          end
          K_COL0: begin
            case (step_r)
              2'd0: begin
                op.z = SUM_W'(rd_q);
                op.x = CNT_W'(1);
                op.y = cost_i.del;
              end
              2'd1: begin
                op.x = CNT_W'(i_r) + 1'b1;
                op.y = cost_i.del;
                op.w = cost_i.ins;
              end
              default: begin
                op.z = rep_z;
                op.x = CNT_W'(i_r);
                op.y = cost_i.del;
              end
            endcase
          end
          default: begin
            case (step_r)
              2'd0: begin
                op.z = SUM_W'(rd_q);
                op.x = CNT_W'(1);
                op.y = cost_i.del;
              end
              2'd1: begin
                op.z = SUM_W'(left_r);
                op.x = CNT_W'(1);
                op.y = cost_i.ins;
              end
              default: begin
                op.z = SUM_W'(diag_r) + rep_z;
              end
            endcase
          end
        endcase
      end
      E_SW1: begin
        op.z = pre_zero ? '0 : SUM_W'(rd_q);
        op.x = CNT_W'(ikd);
        op.y = cost_i.del;
        op.w = cost_i.swp;
      end
      E_SW2: begin
        op.z = tmp_r;
        op.x = CNT_W'(jjd);
        op.y = cost_i.ins;
      end
      default: ;
    endcase
  end

  // stores and the working table
  always_ff @(posedge clk) begin
    if (wr_i.src_we) begin
      src_mem[wr_i.addr] <= wr_i.cp;
    end
    if (wr_i.tgt_we) begin
      tgt_mem[wr_i.addr] <= wr_i.cp;
    end
    if (state_r == E_FETCH) begin
      src_q <= src_mem[i_r];
      tgt_q <= tgt_mem[j_r];
      lk_q  <= lk_mem[j_r];
    end
    if (state_r == E_FETCH || state_r == E_PRE) begin
      rd_q <= cost_mem[rd_addr];
    end
    if (state_r == E_WRITE) begin
      cost_mem[{i_r, j_r}] <= tbl_val;
      if (i_r == '0) begin
        lk_mem[j_r] <= '{valid: eq, k: '0};
      end else if (eq) begin
        lk_mem[j_r] <= '{valid: 1'b1, k: i_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      done_r  <= 1'b0;
      step_r  <= 2'd0;
    end else begin
      case (state_r)
        E_IDLE: begin
          done_r <= 1'b0;
          if (start_i) begin
            i_r     <= '0;
            j_r     <= '0;
            ilast_r <= IDX_W'(ns_i - 1'b1);
            jlast_r <= IDX_W'(nt_i - 1'b1);
            state_r <= E_FETCH;
          end
        end
        E_FETCH: begin
          step_r  <= 2'd0;
          state_r <= E_CALC;
        end
        E_CALC: begin
          best_r <= (step_r == 2'd0) ? res.sum : res.min;
          if (step_r == 2'd0) begin
            up_r <= rd_q;
          end
          if (step_r == 2'd2) begin
            step_r  <= 2'd0;
            state_r <= do_swap ? E_PRE : E_WRITE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        E_PRE: begin
          state_r <= E_SW1;
        end
        E_SW1: begin
          tmp_r   <= res.sum;
          state_r <= E_SW2;
        end
        E_SW2: begin
          best_r  <= res.min;
          state_r <= E_WRITE;
        end
        E_WRITE: begin
          left_r <= tbl_val;
          diag_r <= up_r;
          if (kind == K_COL0) begin
            rm_valid_r <= eq;
            js_r       <= '0;
          end else if (kind == K_IN && eq) begin
            rm_valid_r <= 1'b1;
            js_r       <= j_r;
          end
          if (i_r == ilast_r && j_r == jlast_r) begin
            dist_r  <= tbl_val;
            done_r  <= 1'b1;
            state_r <= E_IDLE;
          end else begin
            if (j_r == jlast_r) begin
              j_r <= '0;
              i_r <= i_r + 1'b1;
            end else begin
              j_r <= j_r + 1'b1;
            end
            state_r <= E_FETCH;
          end
        end
        default: state_r <= E_IDLE;
      endcase
    end
  end

  assign done_o = done_r;
  assign dist_o = dist_r;

endmodule

`default_nettype wire

/* hw/rtl/dl_checker.sv */
`default_nettype none

module dl_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input dl_pkg::dl_in_t  in_data,
  input logic            out_valid,
  input logic            out_ready,
  input dl_pkg::dl_out_t out_data
);
  import dl_pkg::*;

  // hold a result until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STAT_OK) |-> out_data.distance == '0)
    else $error("non-zero distance with error status");

  a_cmp_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.action == ACT_CMP) |=> !in_ready)
    else $error("request taken while compute pending");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("result repeated");

endmodule

bind weighted_damerau_levenshtein_top dl_checker u_dl_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

`default_nettype wire
